// File: design/key_press_classifier_defines.svh
// ---------------------------------------------------------------------------
// Key press classifier assertion macros
// Shared concurrent assertion forms used by the classifier RTL.
// ---------------------------------------------------------------------------
`ifndef KEY_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kpc_pkg.sv
// ---------------------------------------------------------------------------
// Key press classifier package
// Payload types, register map and status codes shared across the block.
// ---------------------------------------------------------------------------
package kpc_pkg;

  localparam int KEY_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LEVELS_W   = 8;
  localparam int TICKS_W    = 16;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LONG      = 3'd2,
    ST_SHORT_CAP = 3'd3,
    ST_LONG_CAP  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVELS = 2'd0,
    REG_SHORT_TICKS   = 2'd1,
    REG_LONG_TICKS    = 2'd2,
    REG_RELEASE_TICKS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [KEY_W-1:0] key_index;
    logic             pin_level;
  } req_t;

  typedef struct packed {
    status_t status_code;
    logic    event_new;
  } rsp_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] active_levels;
    logic [TICKS_W-1:0]  short_ticks;
    logic [TICKS_W-1:0]  long_ticks;
    logic [TICKS_W-1:0]  release_ticks;
  } cfg_t;

endpackage

// File: design/kpc_req_if.sv
// ---------------------------------------------------------------------------
// Key press classifier request channel
// Valid/ready channel carrying one tick or status read item.
// ---------------------------------------------------------------------------
interface kpc_req_if
  import kpc_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/kpc_rsp_if.sv
// ---------------------------------------------------------------------------
// Key press classifier response channel
// Valid/ready channel carrying one status result.
// ---------------------------------------------------------------------------
interface kpc_rsp_if
  import kpc_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/kpc_cfg_regs.sv
// ---------------------------------------------------------------------------
// Key press classifier configuration registers
// Write-only register file for pin polarity and tick thresholds.
// ---------------------------------------------------------------------------
module kpc_cfg_regs
  import kpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_levels <= '0;
      cfg.short_ticks   <= TICKS_W'(5);
      cfg.long_ticks    <= TICKS_W'(200);
      cfg.release_ticks <= TICKS_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACTIVE_LEVELS: cfg.active_levels <= cfg_wdata[LEVELS_W-1:0];
        REG_SHORT_TICKS:   cfg.short_ticks   <= cfg_wdata[TICKS_W-1:0];
        REG_LONG_TICKS:    cfg.long_ticks    <= cfg_wdata[TICKS_W-1:0];
        REG_RELEASE_TICKS: cfg.release_ticks <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/kpc_key_table.sv
// ---------------------------------------------------------------------------
// Key press classifier key table
// Per-key state, flag and counter with the single-item update logic.
// ---------------------------------------------------------------------------
module kpc_key_table
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  req_t item,
  input  logic go,
  output rsp_t result
);

  // Only keys reachable by the index field need storage.
  localparam int STORE_KEYS = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
  localparam int IDX_W      = (STORE_KEYS > 1) ? $clog2(STORE_KEYS) : 1;
  localparam int CMP_W      = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

  status_t                key_state_code [STORE_KEYS];
  logic                   key_event_flag [STORE_KEYS];
  logic [COUNT_WIDTH-1:0] key_counter    [STORE_KEYS];

  logic [IDX_W-1:0]       idx;
  logic                   key_ok;
  logic                   active;
  status_t                code_cur;
  logic                   flag_cur;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] rel;
  status_t                code_next;
  logic                   flag_next;
  logic [COUNT_WIDTH-1:0] cnt_next;

  assign idx      = IDX_W'(item.key_index);
  assign key_ok   = (int'(item.key_index) < NUM_KEYS);
  assign active   = (cfg.active_levels[item.key_index] == item.pin_level);
  assign code_cur = key_state_code[idx];
  assign flag_cur = key_event_flag[idx];
  assign cnt_cur  = key_counter[idx];
  assign cnt_inc  = cnt_cur + COUNT_WIDTH'(1);
  assign cnt_dec  = cnt_cur - COUNT_WIDTH'(1);
  assign rel      = COUNT_WIDTH'(cfg.release_ticks);

  always_comb begin
    code_next = code_cur;
    flag_next = flag_cur;
    cnt_next  = cnt_cur;
    if (item.opcode == OP_READ) begin
      flag_next = 1'b0;
    end else begin
      case (code_cur)
        ST_IDLE: begin
          if (!active) begin
            cnt_next = '0;
          end else if (CMP_W'(cnt_inc) == CMP_W'(cfg.short_ticks)) begin
            code_next = ST_SHORT;
            flag_next = 1'b1;
            cnt_next  = rel;
          end else begin
            cnt_next = cnt_inc;
          end
        end
        ST_SHORT: begin
          if (active) begin
            if (cnt_cur < rel) begin
              cnt_next = rel;
            end else if (CMP_W'(cnt_inc) == CMP_W'(cfg.long_ticks)) begin
              code_next = ST_LONG;
              flag_next = 1'b1;
              cnt_next  = rel;
            end else begin
              cnt_next = cnt_inc;
            end
          end else if (cnt_cur > rel) begin
            cnt_next = rel;
          end else begin
            cnt_next = cnt_dec;
            if (cnt_dec == '0) begin
              code_next = ST_SHORT_CAP;
              flag_next = 1'b1;
            end
          end
        end
        ST_LONG: begin
          if (active) begin
            cnt_next = rel;
          end else begin
            cnt_next = cnt_dec;
            if (cnt_dec == '0) begin
              code_next = ST_LONG_CAP;
              flag_next = 1'b1;
            end
          end
        end
        default: begin
          // captured or unknown: drop back to idle, keep the counter
          code_next = ST_IDLE;
          flag_next = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    result.status_code = ST_IDLE;
    result.event_new   = 1'b0;
    if (key_ok) begin
      if (item.opcode == OP_READ) begin
        result.status_code = code_cur;
        result.event_new   = flag_cur;
      end else begin
        result.status_code = code_next;
        result.event_new   = flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STORE_KEYS; k++) begin
        key_state_code[k] <= ST_IDLE;
        key_event_flag[k] <= 1'b0;
        key_counter[k]    <= '0;
      end
    end else if (go && key_ok) begin
      key_state_code[idx] <= code_next;
      key_event_flag[idx] <= flag_next;
      key_counter[idx]    <= cnt_next;
    end
  end

endmodule

// File: design/key_press_classifier.sv
// ---------------------------------------------------------------------------
// Key press classifier
// Short and long press detection with release hold-off for up to eight keys.
// ---------------------------------------------------------------------------
// The block takes one item per clock while the result side is not stalled,
// with no bubbles, also when consecutive items address the same key. Each
// item yields exactly one result. The per-key update runs while the item
// sits in the input register, and the result is captured into the result
// register, from which it transfers out. The per-key state is read and
// written in the same cycle, so a following item always sees the state
// left by the item before it. A tick (opcode 0) advances the key and
// reports its status after the update; a read (opcode 1) reports the
// status as it stood and clears the key's new-event flag. Items for a key
// index at or beyond NUM_KEYS change nothing and report idle with no
// event. Write configuration only while no item is in flight.
// ---------------------------------------------------------------------------
`include "key_press_classifier_defines.svh"

module key_press_classifier
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  kpc_req_if.sink               req,
  kpc_rsp_if.source             rsp
);

  cfg_t cfg;
  req_t item;
  logic item_valid;
  rsp_t result;
  rsp_t out_data;
  logic out_valid;
  logic out_advance;
  logic go;

  // The result register moves when empty or when the sink takes it.
  assign out_advance = !out_valid || rsp.ready;
  // The held item is processed when the result register can take its result.
  assign go          = item_valid && out_advance;
  assign req.ready   = !item_valid || out_advance;

  kpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kpc_key_table #(
    .NUM_KEYS    (NUM_KEYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .go     (go),
    .result (result)
  );

  // Input register: load on each transfer, hold while the result side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= req.payload;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= result;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  `KPC_ASSERT_NEXT(a_req_loads, clk, rst, req.valid && req.ready, item_valid,
    "transferred item missing from input register")
  `KPC_ASSERT_NEXT(a_item_holds, clk, rst, item_valid && !out_advance, item_valid,
    "stalled item dropped from input register")
  `KPC_ASSERT_NEXT(a_go_result, clk, rst, go, out_valid,
    "processed item produced no result")
  `KPC_ASSERT_NOW(a_event_not_idle, clk, rst, out_valid && out_data.event_new,
    out_data.status_code != ST_IDLE, "new-event flag reported with idle status")

endmodule

// File: tb/kpc_status_checker.sv
// ---------------------------------------------------------------------------
// Key press classifier status checker
// Watches the request, result and register write ports, keeps its own copy
// of every key's press state, predicts each status result and compares it
// field by field with what the block returns, in order.
// ---------------------------------------------------------------------------
module kpc_status_checker
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  kpc_req_if                    req,
  kpc_rsp_if                    rsp,
  output int                    mismatches,
  output int                    pending
);

  localparam int PRINT_CAP = 200;

  logic [LEVELS_W-1:0]    levels_r;
  logic [TICKS_W-1:0]     press_ticks_r;
  logic [TICKS_W-1:0]     hold_ticks_r;
  logic [TICKS_W-1:0]     lift_ticks_r;

  status_t                key_code  [NUM_KEYS];
  logic                   key_flag  [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] key_count [NUM_KEYS];

  rsp_t                   status_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report(input string what, input rsp_t want, input rsp_t got);
    if (mismatches < PRINT_CAP)
      $display("[%0t] status mismatch (%s): expected code %0d event %0d, got code %0d event %0d",
               $time, what, want.status_code, want.event_new, got.status_code, got.event_new);
    mismatches++;
  endtask

  function automatic void enter_state(input int k, input status_t code);
    key_code[k] = code;
    key_flag[k] = 1'b1;
  endfunction

  // Advance one key by one item; return the status the block should report.
  function automatic rsp_t advance_key(input req_t item);
    rsp_t                   res;
    int                     k;
    logic                   pressed;
    logic [COUNT_WIDTH-1:0] lift;
    k    = item.key_index;
    lift = COUNT_WIDTH'(lift_ticks_r);
    res.status_code = ST_IDLE;
    res.event_new   = 1'b0;
    if (k >= NUM_KEYS) return res;
    if (item.opcode == OP_READ) begin
      res.status_code = key_code[k];
      res.event_new   = key_flag[k];
      key_flag[k]     = 1'b0;
      return res;
    end
    pressed = ((k < LEVELS_W) ? levels_r[k] : 1'b0) == item.pin_level;
    case (key_code[k])
      ST_IDLE: begin
        if (pressed) begin
          key_count[k] = key_count[k] + 1'b1;
          if (key_count[k] == press_ticks_r) begin
            enter_state(k, ST_SHORT);
            key_count[k] = lift;
          end
        end else begin
          key_count[k] = '0;
        end
      end
      ST_SHORT: begin
        if (pressed) begin
          if (key_count[k] >= lift) begin
            key_count[k] = key_count[k] + 1'b1;
            if (key_count[k] == hold_ticks_r) begin
              enter_state(k, ST_LONG);
              key_count[k] = lift;
            end
          end else begin
            key_count[k] = lift;
          end
        end else if (key_count[k] > lift) begin
          key_count[k] = lift;
        end else begin
          key_count[k] = key_count[k] - 1'b1;
          if (key_count[k] == '0) enter_state(k, ST_SHORT_CAP);
        end
      end
      ST_LONG: begin
        if (pressed) begin
          key_count[k] = lift;
        end else begin
          key_count[k] = key_count[k] - 1'b1;
          if (key_count[k] == '0) enter_state(k, ST_LONG_CAP);
        end
      end
      default: begin
        key_code[k] = ST_IDLE;
        key_flag[k] = 1'b0;
      end
    endcase
    res.status_code = key_code[k];
    res.event_new   = key_flag[k];
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      levels_r      = '0;
      press_ticks_r = 16'd5;
      hold_ticks_r  = 16'd200;
      lift_ticks_r  = 16'd3;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_code[k]  = ST_IDLE;
        key_flag[k]  = 1'b0;
        key_count[k] = '0;
      end
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_LEVELS: levels_r      = cfg_wdata[LEVELS_W-1:0];
          REG_SHORT_TICKS:   press_ticks_r = cfg_wdata[TICKS_W-1:0];
          REG_LONG_TICKS:    hold_ticks_r  = cfg_wdata[TICKS_W-1:0];
          REG_RELEASE_TICKS: lift_ticks_r  = cfg_wdata[TICKS_W-1:0];
          default: ;
        endcase
      end
      // Retire the oldest prediction first: results trail their items.
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (status_q.size() == 0) begin
          want = '0;
          report("no prediction waiting", want, got);
        end else begin
          want = status_q.pop_front();
          if (got.status_code !== want.status_code && got.event_new !== want.event_new)
            report("status_code, event_new", want, got);
          else if (got.status_code !== want.status_code)
            report("status_code", want, got);
          else if (got.event_new !== want.event_new)
            report("event_new", want, got);
        end
      end
      if (req.valid && req.ready) status_q.push_back(advance_key(req.payload));
    end
    pending = status_q.size();
  end

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// Key press classifier testbench
// Drives tick and status read items through the classifier across several
// register settings, with random idling on both channels, one long result
// back-pressure stretch and drained pauses; the status checker predicts and
// compares every result.
// ---------------------------------------------------------------------------
module tb;
  import kpc_pkg::*;

  // Through the input and result registers of the block, plus margin.
  localparam int SETTLE_CYCLES  = 4;
  // Long result back-pressure: far deeper than the block's pipeline.
  localparam int HOLDOFF_CYCLES = 80;
  // Cycles with no transfer on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kpc_req_if req_ch ();
  kpc_rsp_if rsp_ch ();

  int mismatches;
  int pending;
  int sent;
  int quiet_cycles;

  // Idling switch, shared by sender and receiver; hold-off request for the receiver.
  bit idling_on;
  bit holdoff_req;

  // Current register settings, used only to shape press sequences.
  logic [LEVELS_W-1:0] cur_levels;
  logic [TICKS_W-1:0]  cur_hold;
  logic [TICKS_W-1:0]  cur_lift;

  key_press_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch.sink),
    .rsp       (rsp_ch.source)
  );

  kpc_status_checker status_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  // Change ready at the falling edge only.
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        stall_left  = HOLDOFF_CYCLES;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Keep valid high
  // between back-to-back items; drop it only for an idle burst.
  task automatic offer(input opcode_t op, input logic [KEY_W-1:0] key, input logic pin);
    int   gap;
    req_t item;
    item.opcode    = op;
    item.key_index = key;
    item.pin_level = pin;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= item;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Stop offering, wait for every predicted result, then let the pipe empty.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all four registers, one per cycle; only call with the block idle.
  task automatic load_config(input logic [LEVELS_W-1:0] levels,
                             input logic [TICKS_W-1:0] press_ticks,
                             input logic [TICKS_W-1:0] hold_ticks,
                             input logic [TICKS_W-1:0] lift_ticks);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACTIVE_LEVELS;
    cfg_wdata <= CFG_DATA_W'(levels);
    @(negedge clk);
    cfg_index <= REG_SHORT_TICKS;
    cfg_wdata <= press_ticks;
    @(negedge clk);
    cfg_index <= REG_LONG_TICKS;
    cfg_wdata <= hold_ticks;
    @(negedge clk);
    cfg_index <= REG_RELEASE_TICKS;
    cfg_wdata <= lift_ticks;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_levels = levels;
    cur_hold   = hold_ticks;
    cur_lift   = lift_ticks;
  endtask

  // Mostly whole presses on one key: a run of active ticks of random length
  // (up to the long threshold plus three, at most 48), then a run of inactive
  // ticks, with status reads and stray items on random keys mixed in. The rest
  // is plain noise. Stop once the item quota for this stretch is reached.
  task automatic press_traffic(input int quota);
    int stop_at;
    int key;
    int hold_len;
    int lift_len;
    int press_span;
    int lift_span;
    int n;
    stop_at    = sent + quota;
    press_span = (cur_hold + 3 > 48) ? 48 : cur_hold + 3;
    lift_span  = (cur_lift + 3 > 12) ? 12 : cur_lift + 3;
    while (sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        key      = $urandom_range(0, 7);
        hold_len = $urandom_range(0, press_span);
        lift_len = $urandom_range(0, lift_span);
        for (int j = 0; j < hold_len + lift_len; j++) begin
          if ($urandom_range(0, 5) == 0)
            offer(OP_READ, KEY_W'(key), 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 9) == 0)
            offer(opcode_t'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
          offer(OP_TICK, KEY_W'(key),
                (j < hold_len) ? cur_levels[key] : ~cur_levels[key]);
        end
        offer(OP_READ, KEY_W'(key), 1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n)
          offer(opcode_t'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    idling_on      = 1'b1;
    holdoff_req    = 1'b0;
    sent           = 0;
    quiet_cycles   = 0;
    cur_levels     = '0;
    cur_hold       = 16'd200;
    cur_lift       = 16'd3;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: pin low counts as pressed on every key.
    // Idle read, short press on key 0, read twice to see the flag clear,
    // release through the hold-off into short captured, then back to idle.
    offer(OP_READ, 3'd0, 1'b0);
    repeat (5) offer(OP_TICK, 3'd0, 1'b0);
    offer(OP_READ, 3'd0, 1'b1);
    offer(OP_READ, 3'd0, 1'b0);
    repeat (4) offer(OP_TICK, 3'd0, 1'b1);
    // Highest key: read, an inactive tick, a lone active tick.
    offer(OP_READ, 3'd7, 1'b1);
    offer(OP_TICK, 3'd7, 1'b1);
    offer(OP_TICK, 3'd7, 1'b0);
    press_traffic(100);

    // Tight thresholds: key 5 goes short on its first tick, long on its
    // third, then releases into long captured and drops back to idle.
    settle();
    load_config(8'hA5, 16'd1, 16'd4, 16'd2);
    repeat (4) offer(OP_TICK, 3'd5, 1'b1);
    repeat (2) offer(OP_TICK, 3'd5, 1'b0);
    offer(OP_READ, 3'd5, 1'b0);
    offer(OP_TICK, 3'd5, 1'b0);
    press_traffic(170);

    // All keys active high; halfway through, hold off results for a long
    // stretch while items keep coming so the block backs up.
    settle();
    load_config(8'hFF, 16'd3, 16'd10, 16'd1);
    press_traffic(85);
    holdoff_req = 1'b1;
    press_traffic(85);

    // Zero release hold-off: the countdown wraps below zero.
    // Pause mid-way until every result is back.
    settle();
    load_config(8'h00, 16'd2, 16'd8, 16'd0);
    press_traffic(75);
    settle();
    press_traffic(75);

    // Largest hold-off: the held counter wraps past its top.
    settle();
    load_config(8'h3C, 16'd1, 16'd6, 16'hFFFF);
    press_traffic(110);

    // Largest thresholds: nothing gets past idle.
    settle();
    load_config(8'h5A, 16'hFFFF, 16'hFFFF, 16'd1);
    press_traffic(40);

    // Last stretch at full rate: no idling on either side.
    settle();
    idling_on = 1'b0;
    load_config(LEVELS_W'($urandom_range(0, 255)), 16'd4, 16'd20, 16'd5);
    press_traffic(190);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
